// ===== rtl/pvd_pkg.sv =====
// Shared types, constants and helpers for the prefix varint32 stream decoder.
package pvd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 3;

    localparam logic [BYTE_W-1:0] HDR_TWO  = 8'h80;
    localparam logic [BYTE_W-1:0] HDR_FOUR = 8'hC0;
    localparam logic [BYTE_W-1:0] HDR_FIVE = 8'hE0;

    typedef enum logic [1:0] {
        FORM_ONE  = 2'd0,
        FORM_TWO  = 2'd1,
        FORM_FOUR = 2'd2,
        FORM_FIVE = 2'd3
    } t_form;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              buffer_end;
    } t_item;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] bytes_used;
        logic               truncated;
    } t_result;

    // Total byte count of each form, header included.
    function automatic logic [COUNT_W-1:0] form_total(input t_form kind);
        logic [COUNT_W-1:0] total;
        unique case (kind)
            FORM_ONE:  total = 3'd1;
            FORM_TWO:  total = 3'd2;
            FORM_FOUR: total = 3'd4;
            FORM_FIVE: total = 3'd5;
            default:   total = 3'd1;
        endcase
        return total;
    endfunction

endpackage

// ===== rtl/pvd_stream_if.sv =====
// Valid/ready stream interfaces for the byte input and the decoded result output.
interface pvd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       buffer_end;

    modport source (output valid, output byte_in, output buffer_end, input ready);
    modport sink   (input valid, input byte_in, input buffer_end, output ready);
endinterface

interface pvd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic [2:0]  bytes_used;
    logic        truncated;

    modport source (output valid, output value, output bytes_used, output truncated,
                    input ready);
    modport sink   (input valid, input value, input bytes_used, input truncated,
                    output ready);
endinterface

// ===== rtl/pvd_in_reg.sv =====
// Input register stage: holds one accepted byte until the decode step takes it.
module pvd_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pvd_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_take,
    output pvd_pkg::t_item o_item
);
    import pvd_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  n_valid;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== rtl/pvd_step.sv =====
// Decode step: value state plus the per-byte update and result formation.
module pvd_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  pvd_pkg::t_item   i_item,
    input  logic             i_out_free,
    output logic             o_take,
    output logic             o_res_valid,
    output pvd_pkg::t_result o_res
);
    import pvd_pkg::*;

    logic [COUNT_W-1:0] r_seen;
    t_form              r_form;
    logic [VALUE_W-1:0] r_acc;
    logic [COUNT_W-1:0] n_seen;
    t_form              n_form;
    logic [VALUE_W-1:0] n_acc;

    logic               emit;
    t_result            res;
    logic [COUNT_W-1:0] seen_inc;
    logic [COUNT_W-1:0] total;
    logic [VALUE_W-1:0] acc_shift;
    logic [BYTE_W-1:0]  b;

    assign b         = i_item.byte_in;
    assign acc_shift = {r_acc[VALUE_W-BYTE_W-1:0], b};
    assign seen_inc  = r_seen + 3'd1;
    assign total     = form_total(r_form);

    always_comb begin
        emit   = 1'b0;
        res    = '0;
        n_seen = r_seen;
        n_form = r_form;
        n_acc  = r_acc;
        if (r_seen == '0) begin
            if (b < HDR_TWO) begin
                emit           = 1'b1;
                res.value      = {{(VALUE_W-BYTE_W){1'b0}}, b};
                res.bytes_used = 3'd1;
            end else begin
                n_seen = 3'd1;
                if (b >= HDR_FIVE) begin
                    n_form = FORM_FIVE;
                    n_acc  = '0;
                end else if (b >= HDR_FOUR) begin
                    n_form = FORM_FOUR;
                    n_acc  = {{(VALUE_W-5){1'b0}}, b[4:0]};
                end else begin
                    n_form = FORM_TWO;
                    n_acc  = {{(VALUE_W-6){1'b0}}, b[5:0]};
                end
                if (i_item.buffer_end) begin
                    // cut two-byte form returns the header byte itself
                    emit           = 1'b1;
                    res.value      = (n_form == FORM_TWO) ?
                                     {{(VALUE_W-BYTE_W){1'b0}}, b} : '0;
                    res.bytes_used = 3'd1;
                    res.truncated  = 1'b1;
                end
            end
        end else begin
            n_seen = seen_inc;
            n_acc  = acc_shift;
            if (seen_inc >= total) begin
                emit           = 1'b1;
                res.value      = acc_shift;
                res.bytes_used = seen_inc;
            end else if (i_item.buffer_end) begin
                emit           = 1'b1;
                res.bytes_used = seen_inc;
                res.truncated  = 1'b1;
                // missing bytes count as zero
                case (total - seen_inc)
                    3'd1:    res.value = {acc_shift[VALUE_W-9:0], 8'h00};
                    3'd2:    res.value = {acc_shift[VALUE_W-17:0], 16'h0000};
                    3'd3:    res.value = {acc_shift[VALUE_W-25:0], 24'h000000};
                    default: res.value = acc_shift;
                endcase
            end
        end
        if (emit || i_item.buffer_end) begin
            n_seen = '0;
            n_form = FORM_ONE;
            n_acc  = '0;
        end
    end

    // A byte that gives no result never waits on the output side.
    assign o_take      = i_valid && (!emit || i_out_free);
    assign o_res_valid = o_take && emit;
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_form <= FORM_ONE;
            r_acc  <= '0;
        end else if (o_take) begin
            r_seen <= n_seen;
            r_form <= n_form;
            r_acc  <= n_acc;
        end
    end

endmodule

// ===== rtl/pvd_out_reg.sv =====
// Result register: holds one decoded value until the receiver takes it.
module pvd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  pvd_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output pvd_pkg::t_result o_res
);
    import pvd_pkg::*;

    logic    r_valid;
    t_result r_res;
    logic    n_valid;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== rtl/prefix_varint32_stream_decoder_unit.sv =====
// Prefix-length varint32 stream decoder, top level.
//
// Usage:
//   i_in  : byte stream, one byte per transfer, buffer_end marks the last byte
//           of a buffer. A transfer happens on a clock edge with valid and ready high.
//   o_out : decoded values with their byte count and a truncation flag.
// Each byte enters an input register, the decode step updates the value
// state and forms at most one result, which lands in the output register.
// Throughput is one byte per cycle unless a result waits on a stalled o_out;
// a result passes from the input register through the decode step into the
// output register, which drives it on o_out.
// Bytes that give no result pass the decode step even while o_out stalls;
// a byte that gives a result waits in the input register until the output
// register is free, and only that wait drops i_in.ready.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// decoder to waiting for a header byte. A buffer that ends inside a value
// yields a partial result flagged truncated, and decoding restarts at a header.
module prefix_varint32_stream_decoder_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    pvd_in_if.sink    i_in,
    pvd_out_if.source o_out
);
    import pvd_pkg::*;

    t_item   in_item;
    t_item   reg_item;
    logic    reg_valid;
    logic    take;
    logic    out_free;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign in_item.byte_in    = i_in.byte_in;
    assign in_item.buffer_end = i_in.buffer_end;

    pvd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (in_item),
        .o_valid (reg_valid),
        .i_take  (take),
        .o_item  (reg_item)
    );

    pvd_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (reg_valid),
        .i_item      (reg_item),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    pvd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_ready (o_out.ready),
        .o_free  (out_free),
        .o_valid (o_out.valid),
        .o_res   (out_res)
    );

    assign o_out.value      = out_res.value;
    assign o_out.bytes_used = out_res.bytes_used;
    assign o_out.truncated  = out_res.truncated;

endmodule

// ===== rtl/pvd_checker.sv =====
// Port-level checks for the decoder top level, attached by bind.
module pvd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_value,
    input logic [2:0]  i_out_bytes_used,
    input logic        i_out_truncated
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_bytes_used != 3'd0) && (i_out_bytes_used <= 3'd5)
                        && (i_out_bytes_used != 3'd3 || i_out_truncated))
        else $error("bytes_used out of range");

    a_trunc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_truncated |-> i_out_bytes_used <= 3'd4)
        else $error("truncated result with full five-byte count");

    a_single_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_truncated && i_out_bytes_used == 3'd1
        |-> i_out_value < 32'h80)
        else $error("one-byte value above 0x7F");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind prefix_varint32_stream_decoder_unit pvd_checker u_pvd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_value      (o_out.value),
    .i_out_bytes_used (o_out.bytes_used),
    .i_out_truncated  (o_out.truncated)
);
